/* sv/integer_to_ascii_digits_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the integer to ASCII digits block.
// Each macro expands to a labeled concurrent assertion, or to nothing when
// ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_DIGITS_MACROS_SVH
`define INTEGER_TO_ASCII_DIGITS_MACROS_SVH

`ifndef ASSERT_OFF
// Assertion that is checked only while reset is released.
`define IAD_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assertion that is checked on every clock edge, reset included.
`define IAD_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IAD_ASSERT(name, clk, rst_n, prop, msg)
`define IAD_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

/* sv/iad_pkg.sv */
// ----------------------------------------------------------------------------
// iad_pkg
// Shared types, constants and helpers of the integer to ASCII digits block.
// ----------------------------------------------------------------------------
`default_nettype none

package iad_pkg;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned DIGIT_W    = 4;
  // A decimal magnitude never exceeds 2^(VALUE_BITS-1), which has 10 digits.
  localparam int unsigned DIGITS_MAX = 10;
  localparam int unsigned CNT_W      = $clog2(DIGITS_MAX + 1);

  // Reciprocal of ten: floor(v * RECIP_DEC / 2^DEC_SHIFT) == v / 10 for 32 bits.
  localparam logic [VALUE_BITS-1:0] RECIP_DEC = 32'hCCCC_CCCD;
  localparam int unsigned           DEC_SHIFT = 35;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  localparam logic REQ_HEX = 1'b0;
  localparam logic REQ_DEC = 1'b1;

  typedef struct packed {
    logic                  req_type;
    logic [VALUE_BITS-1:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctrl_t;

  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [7:0] d8;
    d8 = {4'b0, d};
    if (d < 4'd10) begin
      return CHAR_ZERO + d8;
    end
    return CHAR_A + d8 - 8'd10;
  endfunction

endpackage

`default_nettype wire

/* sv/iad_div_step.sv */
// ----------------------------------------------------------------------------
// iad_div_step
// Shared divide unit: one radix-10 or radix-16 digit per use.
// ----------------------------------------------------------------------------
`default_nettype none

module iad_div_step (
  input  logic                             dec_i,
  input  logic [iad_pkg::VALUE_BITS-1:0]   value_i,
  output logic [iad_pkg::VALUE_BITS-1:0]   quot_o,
  output logic [iad_pkg::DIGIT_W-1:0]      digit_o
);
  import iad_pkg::*;

  logic [2*VALUE_BITS-1:0] prod;
  logic [VALUE_BITS-1:0]   quot_dec;
  logic [DIGIT_W-1:0]      ten_q_lo;

  assign prod     = (2*VALUE_BITS)'(value_i) * (2*VALUE_BITS)'(RECIP_DEC);
  assign quot_dec = VALUE_BITS'(prod[2*VALUE_BITS-1:DEC_SHIFT]);
  // The remainder is below ten, so its low four bits are enough to find it.
  assign ten_q_lo = {quot_dec[0], 3'b000} + {quot_dec[2:0], 1'b0};

  always_comb begin
    if (dec_i) begin
      quot_o  = quot_dec;
      digit_o = value_i[DIGIT_W-1:0] - ten_q_lo;
    end else begin
      quot_o  = {{DIGIT_W{1'b0}}, value_i[VALUE_BITS-1:DIGIT_W]};
      digit_o = value_i[DIGIT_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* sv/iad_digit_stack.sv */
// ----------------------------------------------------------------------------
// iad_digit_stack
// Last-in first-out store of digits built from a shift line.
// ----------------------------------------------------------------------------
`default_nettype none

module iad_digit_stack (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  iad_pkg::stack_ctrl_t          ctrl_i,
  input  logic [iad_pkg::DIGIT_W-1:0]   digit_i,
  output logic [iad_pkg::DIGIT_W-1:0]   top_o,
  output logic [iad_pkg::CNT_W-1:0]     count_o
);
  import iad_pkg::*;

  logic [DIGIT_W-1:0] stack_q [DIGITS_MAX];
  logic [DIGIT_W-1:0] stack_d [DIGITS_MAX];
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  // A push shifts everything down one place; a pop shifts it back up.
  always_comb begin
    stack_d = stack_q;
    cnt_d   = cnt_q;
    if (ctrl_i.push) begin
      stack_d[0] = digit_i;
      for (int i = 1; i < DIGITS_MAX; i++) begin
        stack_d[i] = stack_q[i-1];
      end
      cnt_d = cnt_q + CNT_W'(1);
    end else if (ctrl_i.pop) begin
      for (int i = 0; i < DIGITS_MAX - 1; i++) begin
        stack_d[i] = stack_q[i+1];
      end
      stack_d[DIGITS_MAX-1] = '0;
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stack_q <= stack_d;
  end

  assign top_o   = stack_q[0];
  assign count_o = cnt_q;

endmodule

`default_nettype wire

/* sv/integer_to_ascii_digits.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_digits
// Converts a 32-bit value to ASCII hexadecimal or signed decimal characters.
// ----------------------------------------------------------------------------
// The input channel carries one request: a request type (hexadecimal or
// signed decimal) and a 32-bit value. The output channel carries one transfer
// per ASCII character, most significant digit first, with last set on the
// final character. Leading zeros are dropped and zero gives a single '0'.
// A negative decimal value is sent as '-' followed by its magnitude.
// The block takes one request at a time. After acceptance, the shared divide
// unit produces one digit per cycle into a digit stack (up to 8 digits for
// hexadecimal, up to 10 for decimal), and the stack is then unloaded one
// character per cycle, while the output register is free, into that register.
// The minus sign is sent while digits are still being produced if the output
// register is free, and otherwise ahead of the first digit.
// When the receiver stalls, the output register holds its character and the
// sequencer waits; no character is lost. Input ready returns once the final
// character sits in the output register, so the next request can start while
// that character is still waiting. Reset clears the sequencer, the stack fill
// count and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_to_ascii_digits_macros.svh"

module integer_to_ascii_digits (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  iad_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output iad_pkg::out_t out_data_o
);
  import iad_pkg::*;

  // One-hot sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DIVIDE = 3'b010,
    ST_EMIT   = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Working value and request type of the current request.
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic                  dec_q, dec_d;
  // A minus sign still has to be sent ahead of the digits.
  logic                  sign_pend_q, sign_pend_d;

  // Output register.
  logic out_valid_q, out_valid_d;
  out_t out_data_q, out_data_d;

  logic                  in_xfer;
  logic                  out_free;
  logic                  neg;
  logic [VALUE_BITS-1:0] quot;
  logic [DIGIT_W-1:0]    digit;
  logic [DIGIT_W-1:0]    top;
  logic [CNT_W-1:0]      cnt;
  stack_ctrl_t           stack_ctrl;

  // The shared divide unit works on the registered value every cycle.
  iad_div_step u_div (
    .dec_i   (dec_q),
    .value_i (val_q),
    .quot_o  (quot),
    .digit_o (digit)
  );

  // Digits arrive least significant first and leave most significant first.
  iad_digit_stack u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (stack_ctrl),
    .digit_i (digit),
    .top_o   (top),
    .count_o (cnt)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  // The output register can take a new character when it is empty or when
  // its present character is transferred in this cycle.
  assign out_free   = !out_valid_q || out_ready_i;
  assign neg        = (in_data_i.req_type == REQ_DEC) && in_data_i.value[VALUE_BITS-1];

  always_comb begin
    state_d         = state_q;
    val_d           = val_q;
    dec_d           = dec_q;
    sign_pend_d     = sign_pend_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    out_data_d      = out_data_q;
    stack_ctrl.push = 1'b0;
    stack_ctrl.pop  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          dec_d       = (in_data_i.req_type == REQ_DEC);
          sign_pend_d = neg;
          // The most negative value wraps to its own bit pattern, which read
          // as unsigned is exactly its magnitude.
          val_d       = neg ? (~in_data_i.value + VALUE_BITS'(1)) : in_data_i.value;
          state_d     = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        stack_ctrl.push = 1'b1;
        val_d           = quot;
        if (quot == '0) begin
          state_d = ST_EMIT;
        end
        // The sign does not depend on the digits, so it goes out right away.
        if (sign_pend_q && out_free) begin
          sign_pend_d         = 1'b0;
          out_valid_d         = 1'b1;
          out_data_d.out_char = CHAR_MINUS;
          out_data_d.last     = 1'b0;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (sign_pend_q) begin
            sign_pend_d         = 1'b0;
            out_data_d.out_char = CHAR_MINUS;
            out_data_d.last     = 1'b0;
          end else begin
            stack_ctrl.pop      = 1'b1;
            out_data_d.out_char = digit_char(top);
            out_data_d.last     = (cnt == CNT_W'(1));
            if (cnt == CNT_W'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sign_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sign_pend_q <= sign_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    dec_q      <= dec_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The stack is empty whenever a new request may be taken.
  `IAD_ASSERT(a_idle_stack_empty, clk_i, rst_ni, (state_q == ST_IDLE) |-> (cnt == '0), "stack not empty in idle")
  // The stack never overflows while digits are produced.
  `IAD_ASSERT(a_stack_room, clk_i, rst_ni, (state_q == ST_DIVIDE) |-> (cnt < CNT_W'(DIGITS_MAX)), "digit stack overflow")
  // A pending sign belongs only to a decimal request.
  `IAD_ASSERT(a_sign_dec, clk_i, rst_ni, sign_pend_q |-> dec_q, "sign pending on hexadecimal request")
  // Loading the final digit returns the sequencer to idle.
  `IAD_ASSERT(a_last_to_idle, clk_i, rst_ni, (stack_ctrl.pop && (cnt == CNT_W'(1))) |=> (state_q == ST_IDLE && out_valid_q && out_data_q.last), "final digit did not end request")
  // Reset leaves the output channel empty.
  `IAD_ASSERT_ALWAYS(a_reset_out, clk_i, !rst_ni |=> !out_valid_q || rst_ni, "output valid during reset")

endmodule

`default_nettype wire
